// ----- hw/rtl/fdc_pkg.sv -----
// Shared types and constants for the frame deframer with checksum check.
package fdc_pkg;

    localparam int unsigned POS_W     = 17;
    localparam int unsigned HDR_BYTES = 5;

    // Header byte positions
    localparam logic [POS_W-1:0] POS_TYPE   = 17'd0;
    localparam logic [POS_W-1:0] POS_ID_LO  = 17'd1;
    localparam logic [POS_W-1:0] POS_ID_HI  = 17'd2;
    localparam logic [POS_W-1:0] POS_LEN_LO = 17'd3;
    localparam logic [POS_W-1:0] POS_LEN_HI = 17'd4;
    localparam logic [POS_W-1:0] POS_BODY   = 17'(HDR_BYTES);

    localparam logic [15:0] SUM_GOOD = 16'hffff;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       frame_type;
        logic [15:0]      frame_id;
        logic [15:0]      frame_length;
        logic [15:0]      running_sum;
        logic [7:0]       pending_low;
    } fdc_state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  msg_type;
        logic [15:0] comm_id;
        logic [15:0] payload_length;
        logic [15:0] received_checksum;
        logic        checksum_ok;
    } fdc_result_t;

endpackage

// ----- hw/rtl/fdc_step.sv -----
// Per-byte deframing step: header capture, checksum accumulation, result build.
module fdc_step (
    input  fdc_pkg::fdc_state_t  state,
    input  logic [7:0]           rx_byte,
    output fdc_pkg::fdc_state_t  state_next,
    output logic                 res_valid,
    output fdc_pkg::fdc_result_t res
);
    import fdc_pkg::*;

    logic [15:0]      word;
    logic [16:0]      raw_sum;
    logic [15:0]      folded_sum;
    logic [POS_W-1:0] body_end;
    logic [POS_W-1:0] last_pos;
    logic             is_payload;
    logic             is_last;

    assign word    = {rx_byte, state.pending_low};
    assign raw_sum = {1'b0, state.running_sum} + {1'b0, word};
    // end-around carry; cannot overflow again
    assign folded_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};

    always_comb
    begin
        state_next     = state;
        state_next.pos = state.pos + 17'd1;

        case (state.pos)
            POS_TYPE:   state_next.frame_type         = rx_byte;
            POS_ID_LO:  state_next.frame_id[7:0]      = rx_byte;
            POS_ID_HI:  state_next.frame_id[15:8]     = rx_byte;
            POS_LEN_LO: state_next.frame_length[7:0]  = rx_byte;
            POS_LEN_HI: state_next.frame_length[15:8] = rx_byte;
            default:    ;
        endcase

        if (!state.pos[0])
        begin
            state_next.pending_low = rx_byte;
        end
        else
        begin
            state_next.running_sum = folded_sum;
        end

        // length must come from the updated header
        body_end = POS_BODY + {1'b0, state_next.frame_length};
        // pad byte when length even, then two checksum bytes
        last_pos = body_end + (state_next.frame_length[0] ? 17'd1 : 17'd2);

        is_payload = (state.pos >= POS_BODY) && (state.pos < body_end);
        is_last    = (state.pos >= POS_BODY) && (state.pos == last_pos);

        res_valid               = is_payload || is_last;
        res.kind                = is_last ? KIND_STATUS : KIND_PAYLOAD;
        res.data_byte           = is_last ? 8'd0 : rx_byte;
        res.msg_type            = state_next.frame_type;
        res.comm_id             = state_next.frame_id;
        res.payload_length      = state_next.frame_length;
        res.received_checksum   = is_last ? word : 16'd0;
        res.checksum_ok         = is_last && (state_next.running_sum == SUM_GOOD);

        if (is_last)
        begin
            state_next.pos         = '0;
            state_next.running_sum = '0;
        end
    end

endmodule

// ----- hw/rtl/fdc_skid.sv -----
// Result register with one skid entry so input acceptance is decoupled from output stall.
module fdc_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fdc_pkg::fdc_result_t push_res,
    input  logic                 out_stall,
    output logic                 out_valid,
    output fdc_pkg::fdc_result_t out_res,
    output logic                 full
);
    import fdc_pkg::*;

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    fdc_result_t main_res_reg, main_res_next;
    fdc_result_t skid_res_reg, skid_res_next;
    logic        take;

    assign take      = main_valid_reg && !out_stall;
    assign out_valid = main_valid_reg;
    assign out_res   = main_res_reg;
    assign full      = skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_res_next   = main_res_reg;
        skid_res_next   = skid_res_reg;

        if (skid_valid_reg)
        begin
            // no push possible while full
            if (take)
            begin
                main_res_next   = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || take)
            begin
                main_res_next   = push_res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_res_next   = push_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_res_reg <= main_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule

// ----- hw/rtl/frame_deframe_checksum_check_top.sv -----
// Top level of the frame deframer with 16-bit ones'-complement checksum check.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  in      | in_valid/in_stall  | rx_byte
//  out     | out_valid/out_stall| kind, data_byte, msg_type, comm_id, payload_length,
//          |                    | received_checksum, checksum_ok
//
// One request per cycle unless in_stall; each result is registered in the skid block.
// The frame state updates in the same cycle a byte is taken; the 17-bit end-position
// adds and compare and the 16-bit adder with end-around carry set the cycle.
// Reset clears position, header fields and running sum; no other startup delay.
// A stalled output fills a one-entry skid; in_stall rises only once both are full.
module frame_deframe_checksum_check_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  msg_type,
    output logic [15:0] comm_id,
    output logic [15:0] payload_length,
    output logic [15:0] received_checksum,
    output logic        checksum_ok
);
    import fdc_pkg::*;

    fdc_state_t  state_reg, state_next;
    fdc_result_t step_res;
    fdc_result_t out_res;
    logic        step_res_valid;
    logic        accept;
    logic        skid_full;

    assign in_stall = skid_full;
    assign accept   = in_valid && !skid_full;

    fdc_step u_step (
        .state      (state_reg),
        .rx_byte    (rx_byte),
        .state_next (state_next),
        .res_valid  (step_res_valid),
        .res        (step_res)
    );

    fdc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && step_res_valid),
        .push_res  (step_res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .full      (skid_full)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    assign kind              = out_res.kind;
    assign data_byte         = out_res.data_byte;
    assign msg_type          = out_res.msg_type;
    assign comm_id           = out_res.comm_id;
    assign payload_length    = out_res.payload_length;
    assign received_checksum = out_res.received_checksum;
    assign checksum_ok       = out_res.checksum_ok;

endmodule

// ----- hw/rtl/fdc_checker.sv -----
// Port-level assertions for the deframer top level, with the bind that attaches them.
module fdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kind,
    input logic [7:0]  data_byte,
    input logic [15:0] received_checksum,
    input logic        checksum_ok
);
    import fdc_pkg::*;

    // a pending result is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // input only backs up when a result is already waiting
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without pending result");

    // skid drains as soon as the output moves
    a_stall_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("in_stall held after output taken");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PAYLOAD) |-> (received_checksum == 16'd0) && !checksum_ok)
        else $error("payload result carries status fields");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_STATUS) |-> (data_byte == 8'd0))
        else $error("status result carries a data byte");

endmodule

bind frame_deframe_checksum_check_top fdc_checker u_fdc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .data_byte         (data_byte),
    .received_checksum (received_checksum),
    .checksum_ok       (checksum_ok)
);
